@@ sv/assert_macros.svh @@
// Assertion macros used by the predictor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define TBP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// Next-cycle implication, checked at every rising edge outside reset.
`define TBP_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`else

`define TBP_ASSERT_IMP(name, clk, rst, ante, cons)
`define TBP_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

@@ sv/tbp_pkg.sv @@
// Types, constants and counter helpers for the tournament branch predictor.
package tbp_pkg;

  localparam int INDEX_BITS_DEFAULT = 11;
  localparam int HIST_BITS          = 11;

  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'd0;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CALC  = 3'b100
  } tbp_state_t;

  // Two-bit saturating counter step.
  function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

@@ sv/tournament_branch_predictor.sv @@
// Tournament branch predictor: gshare and bimodal tables with a per-address chooser.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one resolved branch per word:
//   branch_address and taken. Output channel (out_valid / out_stall) returns one
//   word per branch: the chosen prediction, whether the chosen, gshare and
//   bimodal predictions were right, and the running count of correct chosen
//   predictions (wraps at 32 bits).
//   The table memories are read at the edge that accepts the word and written
//   back at the edge that loads the result word into the output register.
//   A new branch is not accepted until the previous one has been written back,
//   because of this read-modify-write of the counter memories. The result word
//   is loaded from the compute state once the output register is free.
//   After reset a clearing pass over all 2**INDEX_BITS entries sets every
//   counter to its initial value; in_stall stays high during it.
//   While the receiver stalls a pending result, one more branch can be accepted
//   and read; it waits in the compute state until the output register frees.
`include "assert_macros.svh"

module tournament_branch_predictor
  import tbp_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predicted_taken,
  output logic        prediction_correct,
  output logic        gshare_correct,
  output logic        bimodal_correct,
  output logic [31:0] correct_count
);

  localparam int DEPTH = 1 << INDEX_BITS;

  tbp_state_t state, state_next;

  logic [INDEX_BITS-1:0] clr_idx;
  logic [HIST_BITS-1:0]  hist;
  logic [INDEX_BITS-1:0] gidx, bidx;
  logic [INDEX_BITS-1:0] gidx_q, bidx_q;
  logic                  taken_q;
  logic [INDEX_BITS+HIST_BITS-1:0] hist_wide;

  // Gshare counters, and bimodal/chooser counters packed as {bimodal, chooser}.
  logic [1:0] gsh_mem [DEPTH];
  logic [3:0] bc_mem  [DEPTH];
  logic [1:0] gsh_rdata;
  logic [3:0] bc_rdata;

  logic                  in_acc, res_load;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] gsh_waddr, bc_waddr;
  logic [1:0]            gsh_wdata;
  logic [3:0]            bc_wdata;

  logic       gpred, bpred, pred, gok, bok, ok;
  logic [1:0] sel, sel_new;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign res_load = (state == S_CALC) && (!out_valid || !out_stall);

  // History only reaches the low index bits; a short index drops its upper bits.
  assign hist_wide = {{INDEX_BITS{1'b0}}, hist};
  assign bidx      = branch_address[INDEX_BITS-1:0];
  assign gidx      = branch_address[INDEX_BITS-1:0] ^ hist_wide[INDEX_BITS-1:0];

  assign gpred = gsh_rdata[1];
  assign bpred = bc_rdata[3];
  assign sel   = bc_rdata[1:0];
  assign pred  = sel[1] ? bpred : gpred;
  assign gok   = (gpred == taken_q);
  assign bok   = (bpred == taken_q);
  assign ok    = (pred == taken_q);

  always_comb begin
    if (gok && !bok) begin
      sel_new = ctr_train(sel, 1'b0);
    end else if (bok && !gok) begin
      sel_new = ctr_train(sel, 1'b1);
    end else begin
      sel_new = sel;
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      gsh_waddr = clr_idx;
      bc_waddr  = clr_idx;
      gsh_wdata = CTR_MAX;
      bc_wdata  = {CTR_MAX, CTR_MIN};
    end else begin
      mem_we    = res_load;
      gsh_waddr = gidx_q;
      bc_waddr  = bidx_q;
      gsh_wdata = ctr_train(gsh_rdata, taken_q);
      bc_wdata  = {ctr_train(bc_rdata[3:2], taken_q), sel_new};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gsh_mem[gsh_waddr] <= gsh_wdata;
      bc_mem[bc_waddr]   <= bc_wdata;
    end
    if (in_acc) begin
      gsh_rdata <= gsh_mem[gidx];
      bc_rdata  <= bc_mem[bidx];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == {INDEX_BITS{1'b1}}) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_next = S_CALC;
      end
      S_CALC: begin
        if (res_load) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      hist          <= '0;
      correct_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (res_load) begin
        hist          <= {hist[HIST_BITS-2:0], taken_q};
        correct_count <= correct_count + {31'd0, ok};
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gidx_q  <= gidx;
      bidx_q  <= bidx;
      taken_q <= taken;
    end
    if (res_load) begin
      predicted_taken    <= pred;
      prediction_correct <= ok;
      gshare_correct     <= gok;
      bimodal_correct    <= bok;
    end
  end

  `TBP_ASSERT_IMP(a_no_accept_in_clear, clk, rst, state == S_CLEAR, in_stall)
  `TBP_ASSERT_NXT(a_accept_to_calc, clk, rst, in_acc, state == S_CALC)
  `TBP_ASSERT_IMP(a_agree_pick, clk, rst, out_valid && (gshare_correct == bimodal_correct), prediction_correct == gshare_correct)
  `TBP_ASSERT_NXT(a_count_hold, clk, rst, !res_load && !rst, $stable(correct_count))

endmodule
